>>> sv/vtd_pkg.sv
// Shared types and constants for the vertex transform and divide block.
// Depends on nothing; every other file imports it.
package vtd_pkg;

    // Default number of fraction bits of the fixed-point format.
    localparam int VTD_FRAC_BITS = 16;

    // Width of one fixed-point value.
    localparam int VTD_WORD_W = 32;

    // Request type codes.
    localparam logic REQ_WRITE  = 1'b0;
    localparam logic REQ_VERTEX = 1'b1;

    // Matrix select codes.
    localparam logic SEL_MODELVIEW  = 1'b0;
    localparam logic SEL_PROJECTION = 1'b1;

    // Control that travels with each word through the matrix stages.
    typedef struct packed {
        logic        vld;
        logic        is_vtx;
        logic        sel;
        logic [3:0]  idx;
        logic [31:0] value;
    } vtd_ctl_t;

    // Four fixed-point values, element 0 first.
    typedef logic [3:0][31:0] vtd_vec_t;

endpackage

>>> sv/vtd_mat_stage.sv
// One 4x4 matrix store and its two-stage matrix-vector product.
// Depends on vtd_pkg.
module vtd_mat_stage
    import vtd_pkg::*;
#(
    parameter int FRAC_BITS = VTD_FRAC_BITS,
    parameter logic MAT_ID  = SEL_MODELVIEW
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     en,
    input  vtd_ctl_t ctl_in,
    input  vtd_vec_t vec_in,
    output vtd_ctl_t ctl_out,
    output vtd_vec_t vec_out
);

    localparam logic [31:0] ONE = 32'(64'd1 << FRAC_BITS);

    logic [15:0][31:0] mat_reg;
    logic [15:0][63:0] prod_reg;
    logic [15:0][63:0] prod_next;
    vtd_ctl_t          ctl1_reg;
    vtd_ctl_t          ctl2_reg;
    vtd_vec_t          row_reg;
    vtd_vec_t          row_next;
    logic              wr_hit;

    assign wr_hit = ctl_in.vld && (ctl_in.is_vtx == REQ_WRITE) && (ctl_in.sel == MAT_ID);

    // Matrix store, reset to identity; a write word lands as it enters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 16; i++)
            begin
                mat_reg[i] <= (i % 5 == 0) ? ONE : 32'd0;
            end
        end
        else if (en && wr_hit)
        begin
            mat_reg[ctl_in.idx] <= ctl_in.value;
        end
    end

    // All sixteen exact products of the matrix with the vector.
    always_comb
    begin
        for (int i = 0; i < 16; i++)
        begin
            prod_next[i] = 64'($signed(mat_reg[i]) * $signed(vec_in[i / 4]));
        end
    end

    // Row sums: exact, floor shift, saturate.
    always_comb
    begin
        logic signed [65:0] sum;
        logic signed [65:0] sh;
        for (int r = 0; r < 4; r++)
        begin
            sum = 66'($signed(prod_reg[r]))      + 66'($signed(prod_reg[4 + r]))
                + 66'($signed(prod_reg[8 + r]))  + 66'($signed(prod_reg[12 + r]));
            sh  = sum >>> FRAC_BITS;
            if (sh[65:31] != {35{sh[65]}})
            begin
                row_next[r] = sh[65] ? 32'h8000_0000 : 32'h7FFF_FFFF;
            end
            else
            begin
                row_next[r] = sh[31:0];
            end
        end
    end

    // Control registers of both stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
        end
        else if (en)
        begin
            ctl1_reg <= ctl_in;
            ctl2_reg <= ctl1_reg;
        end
    end

    // Payload registers of both stages.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
            row_reg  <= row_next;
        end
    end

    assign ctl_out = ctl2_reg;
    assign vec_out = row_reg;

endmodule

>>> sv/vtd_div_pipe.sv
// Pipelined restoring divider for x, y and z by clip w, one quotient bit a stage.
// Depends on vtd_pkg.
module vtd_div_pipe
    import vtd_pkg::*;
#(
    parameter int FRAC_BITS = VTD_FRAC_BITS
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic        vld_in,
    input  vtd_vec_t    clip_in,
    output logic        vld_out,
    output logic [31:0] x_out,
    output logic [31:0] y_out,
    output logic [31:0] z_out,
    output logic        wzero_out
);

    localparam int QB = 32 + FRAC_BITS;

    typedef struct packed {
        logic [32:0]   rem;
        logic [QB-1:0] nq;
        logic          neg;
        logic [31:0]   orig;
    } lane_t;

    logic  [QB:0]   vld_reg;
    lane_t [2:0]    ln_reg  [QB+1];
    logic  [31:0]   den_reg [QB+1];
    logic           wz_reg  [QB+1];
    logic  [2:0][31:0] res;

    // Stage zero: magnitudes and signs.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            den_reg[0] <= clip_in[3][31] ? 32'(-clip_in[3]) : clip_in[3];
            wz_reg[0]  <= (clip_in[3] == 32'd0);
            for (int l = 0; l < 3; l++)
            begin
                ln_reg[0][l].rem  <= '0;
                ln_reg[0][l].nq   <= {(clip_in[l][31] ? 32'(-clip_in[l]) : clip_in[l]),
                                      {FRAC_BITS{1'b0}}};
                ln_reg[0][l].neg  <= clip_in[l][31] ^ clip_in[3][31];
                ln_reg[0][l].orig <= clip_in[l];
            end
        end
    end

    // Valid bits travel alongside the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[QB-1:0], vld_in};
        end
    end

    // One quotient bit per stage for each lane.
    for (genvar k = 1; k <= QB; k++)
    begin : g_step
        always_ff @(posedge clk)
        begin
            logic [32:0] t;
            logic        ge;
            if (en)
            begin
                den_reg[k] <= den_reg[k-1];
                wz_reg[k]  <= wz_reg[k-1];
                for (int l = 0; l < 3; l++)
                begin
                    t  = {ln_reg[k-1][l].rem[31:0], ln_reg[k-1][l].nq[QB-1]};
                    ge = (t >= {1'b0, den_reg[k-1]});
                    ln_reg[k][l].rem  <= ge ? (t - {1'b0, den_reg[k-1]}) : t;
                    ln_reg[k][l].nq   <= {ln_reg[k-1][l].nq[QB-2:0], ge};
                    ln_reg[k][l].neg  <= ln_reg[k-1][l].neg;
                    ln_reg[k][l].orig <= ln_reg[k-1][l].orig;
                end
            end
        end
    end

    // Sign, saturation and the zero-w bypass.
    always_comb
    begin
        logic [QB-1:0] q;
        for (int l = 0; l < 3; l++)
        begin
            q = ln_reg[QB][l].nq;
            if (wz_reg[QB])
            begin
                res[l] = ln_reg[QB][l].orig;
            end
            else if (ln_reg[QB][l].neg)
            begin
                res[l] = (q[QB-1:31] != '0) ? 32'h8000_0000 : 32'(-q[31:0]);
            end
            else
            begin
                res[l] = (q[QB-1:31] != '0) ? 32'h7FFF_FFFF : q[31:0];
            end
        end
    end

    assign vld_out   = vld_reg[QB];
    assign x_out     = res[0];
    assign y_out     = res[1];
    assign z_out     = res[2];
    assign wzero_out = wz_reg[QB];

endmodule

>>> sv/vertex_transform_divide.sv
// Top level of the vertex transform and perspective divide block.
// Depends on vtd_pkg, vtd_mat_stage and vtd_div_pipe.
//
// Request channel (req_valid, req_stall): each word either writes one element
// of the modelview or projection matrix (req_type 0) or carries a vertex
// (req_type 1). Result channel (res_valid, res_stall): one word per vertex,
// none per matrix write.
// Data (Q16.16 by default) pass the product and row-sum registers of both
// matrix stages, the divider's set-up register and one register per quotient
// bit, and the output register. One word is accepted every cycle unless stalled.
// Matrix writes take effect in order: a vertex sees every write accepted
// before it and none after it.
// Reset loads both matrices with identity and empties the pipeline.
// When the receiver stalls while a result waits, the whole pipeline holds and
// req_stall rises; nothing is dropped or repeated.
module vertex_transform_divide
    import vtd_pkg::*;
#(
    parameter int FRAC_BITS = VTD_FRAC_BITS
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_stall,
    input  logic        req_type,
    input  logic        matrix_sel,
    input  logic [3:0]  elem_index,
    input  logic [31:0] elem_value,
    input  logic [31:0] vx,
    input  logic [31:0] vy,
    input  logic [31:0] vz,
    output logic        res_valid,
    input  logic        res_stall,
    output logic [31:0] out_x,
    output logic [31:0] out_y,
    output logic [31:0] out_z,
    output logic        w_was_zero
);

    localparam logic [31:0] ONE = 32'(64'd1 << FRAC_BITS);

    logic        en;
    vtd_ctl_t    ctl0;
    vtd_ctl_t    ctl_mv;
    vtd_ctl_t    ctl_pj;
    vtd_vec_t    vec0;
    vtd_vec_t    vec_mv;
    vtd_vec_t    vec_pj;
    logic        dv_vld;
    logic [31:0] dx;
    logic [31:0] dy;
    logic [31:0] dz;
    logic        dwz;
    logic        res_valid_reg;
    logic [31:0] x_reg;
    logic [31:0] y_reg;
    logic [31:0] z_reg;
    logic        wz_reg;

    // The pipeline moves unless a result is waiting and held back.
    assign en        = !res_valid_reg || !res_stall;
    assign req_stall = !en;

    assign ctl0 = '{vld: req_valid, is_vtx: req_type, sel: matrix_sel,
                    idx: elem_index, value: elem_value};
    assign vec0 = {ONE, vz, vy, vx};

    // Modelview product.
    vtd_mat_stage #(.FRAC_BITS(FRAC_BITS), .MAT_ID(SEL_MODELVIEW)) u_mv (
        .clk(clk), .rst_n(rst_n), .en(en),
        .ctl_in(ctl0), .vec_in(vec0), .ctl_out(ctl_mv), .vec_out(vec_mv)
    );

    // Projection product; its writes land as they reach this stage.
    vtd_mat_stage #(.FRAC_BITS(FRAC_BITS), .MAT_ID(SEL_PROJECTION)) u_pj (
        .clk(clk), .rst_n(rst_n), .en(en),
        .ctl_in(ctl_mv), .vec_in(vec_mv), .ctl_out(ctl_pj), .vec_out(vec_pj)
    );

    // Perspective divide; write words leave the pipeline here.
    vtd_div_pipe #(.FRAC_BITS(FRAC_BITS)) u_div (
        .clk(clk), .rst_n(rst_n), .en(en),
        .vld_in(ctl_pj.vld && (ctl_pj.is_vtx == REQ_VERTEX)), .clip_in(vec_pj),
        .vld_out(dv_vld), .x_out(dx), .y_out(dy), .z_out(dz), .wzero_out(dwz)
    );

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            res_valid_reg <= dv_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg  <= dx;
            y_reg  <= dy;
            z_reg  <= dz;
            wz_reg <= dwz;
        end
    end

    assign res_valid  = res_valid_reg;
    assign out_x      = x_reg;
    assign out_y      = y_reg;
    assign out_z      = z_reg;
    assign w_was_zero = wz_reg;

endmodule
